// ----- hdl/rss_pkg.sv -----
// Shared types and codes for the record stack with name sort.
// Used by the top level record_stack_with_name_sort; no dependencies.
package rss_pkg;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_SORT = 2'd2;
  localparam logic [1:0] REQ_DUMP = 2'd3;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] rec_name;
    logic [7:0]  rec_kind;
    logic [31:0] rec_temp_a;
    logic [31:0] rec_temp_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_count;
    logic        is_sorted;
    logic [63:0] out_name;
    logic [7:0]  out_kind;
    logic [31:0] out_temp_a;
    logic [31:0] out_temp_b;
    logic        last;
  } out_item_t;

  // One table entry as held in the record memory.
  typedef struct packed {
    logic [63:0] name;
    logic [7:0]  kind;
    logic [31:0] temp_a;
    logic [31:0] temp_b;
  } record_t;

endpackage

// ----- hdl/rss_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rss_ram #(
  parameter int WIDTH = 136,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/record_stack_with_name_sort.sv -----
// Top level of the record stack with name sort: request sequencer around one record RAM.
// Depends on rss_pkg and rss_ram.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (push, pop, sort, dump); results
//   leave on out_valid/out_ready/out_data. Every transfer happens when valid and
//   ready are both high. Push, pop and sort give one result; dump gives one result
//   per stored record (bottom of the stack first, last set on the final one), or a
//   single empty-table result.
//   One request is worked on at a time; in_ready is high only when the sequencer is
//   idle. A finished result sits in the output register, so the next request can be
//   taken while it waits.
//   Dump gives one result per cycle after the first read, unless the receiver
//   stalls. Sort of n records walks the exchange loop through the single RAM read
//   port, one compare per cycle plus a load and a write-back per outer step.
//   Reset clears the fill count and the sorted flag; the RAM is not cleared since
//   entries above the fill count are never read.
//   When the receiver stalls, the result holds in the output register and the
//   sequencer waits before producing the next one.
module record_stack_with_name_sort #(
  parameter int CAPACITY = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rss_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rss_pkg::out_item_t out_data
);
  import rss_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $bits(record_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SORT_CUR,
    S_SORT_CMP,
    S_SORT_WB,
    S_SORT_DONE,
    S_DUMP
  } state_t;

  state_t    state_r, state_nxt;
  in_item_t  req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic      sorted_r, sorted_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  record_t   cur_r, cur_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  record_t       mem_wdata;
  logic [AW-1:0] mem_raddr;
  record_t       mem_rdata;

  logic          slot_free;
  logic          out_load;
  logic [1:0]    out_status;
  logic          out_last;
  record_t       out_rec;
  logic          j_at_top;
  logic          i_at_end;

  rss_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign j_at_top  = (CW'(j_r) + CW'(1)) == cnt_r;
  assign i_at_end  = (CW'(i_r) + CW'(2)) == cnt_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cnt_nxt    = cnt_r;
    sorted_nxt = sorted_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    mem_we     = 1'b0;
    mem_waddr  = j_r;
    mem_wdata  = cur_r;
    mem_raddr  = j_r;
    out_load   = 1'b0;
    out_status = STAT_DONE;
    out_last   = 1'b1;
    out_rec    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r.req_type)
          REQ_PUSH: begin
            if (slot_free) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == CW'(CAPACITY)) begin
                out_status = STAT_IGNORED;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_r[AW-1:0];
                mem_wdata  = '{name:   req_r.rec_name,
                               kind:   req_r.rec_kind,
                               temp_a: req_r.rec_temp_a,
                               temp_b: req_r.rec_temp_b};
                cnt_nxt    = cnt_r + CW'(1);
                sorted_nxt = 1'b0;
              end
            end
          end
          REQ_POP: begin
            if (slot_free) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == '0) begin
                out_status = STAT_IGNORED;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
          end
          REQ_SORT: begin
            if (cnt_r < CW'(2)) begin
              if (slot_free) begin
                out_load  = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              i_nxt     = '0;
              mem_raddr = '0;
              state_nxt = S_SORT_CUR;
            end
          end
          REQ_DUMP: begin
            if (cnt_r == '0) begin
              if (slot_free) begin
                out_load   = 1'b1;
                out_status = STAT_EMPTY;
                state_nxt  = S_IDLE;
              end
            end else begin
              j_nxt     = '0;
              mem_raddr = '0;
              state_nxt = S_DUMP;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // The smallest name seen so far for slot i is held in cur_r for the whole inner pass.
      S_SORT_CUR: begin
        cur_nxt   = mem_rdata;
        j_nxt     = i_r + AW'(1);
        mem_raddr = i_r + AW'(1);
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (cur_r.name > mem_rdata.name) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if (j_at_top) begin
          state_nxt = S_SORT_WB;
        end else begin
          j_nxt     = j_r + AW'(1);
          mem_raddr = j_r + AW'(1);
        end
      end
      S_SORT_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        if (i_at_end) begin
          state_nxt = S_SORT_DONE;
        end else begin
          i_nxt     = i_r + AW'(1);
          mem_raddr = i_r + AW'(1);
          state_nxt = S_SORT_CUR;
        end
      end
      S_SORT_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          sorted_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP: begin
        // Read address stays on j while the output is stalled.
        if (slot_free) begin
          out_load = 1'b1;
          out_rec  = mem_rdata;
          out_last = j_at_top;
          if (j_at_top) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + AW'(1);
            mem_raddr = j_r + AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_data_nxt = '{status:      out_status,
                       entry_count: 4'(cnt_nxt),
                       is_sorted:   sorted_nxt,
                       out_name:    out_rec.name,
                       out_kind:    out_rec.kind,
                       out_temp_a:  out_rec.temp_a,
                       out_temp_b:  out_rec.temp_b,
                       last:        out_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
